>>> src/umtd_pkg.sv
// Package for the millisecond-timestamp to UTC calendar converter.
// Field widths, divisor constants, shared struct types and the month-start table.
// No dependencies.
package umtd_pkg;

    localparam int MS_W    = 48;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int MILLI_W = 10;

    localparam int LAST_YEAR = 9999;

    // serial divider datapath
    localparam int QUO_W = 48;
    localparam int REM_W = 18;
    localparam int CNT_W = 6;

    // intermediate widths
    localparam int SECS_W = 39;
    localparam int SOD_W  = 17;
    localparam int SOH_W  = 12;
    localparam int DAYS_W = 22;
    localparam int DOC_W  = 18;
    localparam int CYC_W  = 5;
    localparam int YOC_W  = 9;
    localparam int DOY_W  = 9;
    localparam int MP_W   = 4;
    localparam int MPV_W  = 11;

    localparam int MS_PER_SEC      = 1000;
    localparam int SEC_PER_DAY     = 86400;
    localparam int SEC_PER_HOUR    = 3600;
    localparam int SEC_PER_MIN     = 60;
    localparam int EPOCH_SHIFT     = 719468;
    localparam int CYCLE_DAYS      = 146097;
    localparam int DAYS_PER_4Y     = 1460;
    localparam int DAYS_PER_CENT   = 36524;
    localparam int YEAR_DAYS       = 365;
    localparam int MP_DIVISOR      = 153;
    localparam int YEARS_PER_CYCLE = 400;
    localparam int MP_JAN          = 10;
    localparam int EPOCH_YEAR      = 1970;

    // quotient bits produced by each division
    localparam int STEP_MS  = 39;
    localparam int STEP_DAY = 23;
    localparam int STEP_HR  = 5;
    localparam int STEP_MIN = 6;
    localparam int STEP_CYC = 5;
    localparam int STEP_4Y  = 7;
    localparam int STEP_YOC = 9;
    localparam int STEP_MP  = 4;

    typedef struct packed {
        logic              start;
        logic [REM_W-1:0]  divisor;
        logic [REM_W-1:0]  rem_init;
        logic [QUO_W-1:0]  quot_init;
        logic [CNT_W-1:0]  steps;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  quot;
        logic [REM_W-1:0]  rem;
    } div_rsp_t;

    typedef struct packed {
        logic               in_range;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic [MILLI_W-1:0] milli;
    } cal_res_t;

    // first day of each month, counted from March 1
    function automatic logic [DOY_W-1:0] mp_day_base(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

>>> src/umtd_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, shared by every division.
// Depends on umtd_pkg (div_req_t, div_rsp_t, widths).
module umtd_div
    import umtd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [QUO_W-1:0] quot_reg, quot_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [REM_W-1:0] dvsr_reg, dvsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    logic           ge;

    assign trial = {rem_reg, quot_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, dvsr_reg};
    assign ge    = trial >= {1'b0, dvsr_reg};

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start) begin
            quot_next = req.quot_init;
            rem_next  = req.rem_init;
            dvsr_next = req.divisor;
            cnt_next  = req.steps;
        end else if (cnt_reg != '0) begin
            rem_next  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            quot_next = {quot_reg[QUO_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> src/umtd_seq.sv
// Conversion sequencer: issues the chain of divisions and assembles the calendar result.
// Depends on umtd_pkg and umtd_div.
module umtd_seq
    import umtd_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [MS_W-1:0] millis,
    input  logic            take,
    output logic            idle,
    output logic            res_valid,
    output cal_res_t        res
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MS    = 4'd1;
    localparam logic [3:0] ST_DAY   = 4'd2;
    localparam logic [3:0] ST_HR    = 4'd3;
    localparam logic [3:0] ST_MIN   = 4'd4;
    localparam logic [3:0] ST_CYC   = 4'd5;
    localparam logic [3:0] ST_4Y    = 4'd6;
    localparam logic [3:0] ST_YOC   = 4'd7;
    localparam logic [3:0] ST_MPI   = 4'd8;
    localparam logic [3:0] ST_MP    = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0]         state_reg, state_next;
    logic [MILLI_W-1:0] milli_reg, milli_next;
    logic [DAYS_W-1:0]  days_reg, days_next;
    logic [HOUR_W-1:0]  hour_reg, hour_next;
    logic [MIN_W-1:0]   minute_reg, minute_next;
    logic [SEC_W-1:0]   second_reg, second_next;
    logic [CYC_W-1:0]   cyc_reg, cyc_next;
    logic [DOC_W-1:0]   doc_reg, doc_next;
    logic [YOC_W-1:0]   yoc_reg, yoc_next;
    logic [DOY_W-1:0]   doy_reg, doy_next;
    cal_res_t           res_reg, res_next;

    div_req_t req;
    div_rsp_t rsp;

    logic [SECS_W-1:0]  secs_w;
    logic [SOD_W-1:0]   sod_w;
    logic [SOH_W-1:0]   soh_w;
    logic [DAYS_W-1:0]  z_w;
    logic [DOC_W-1:0]   x_w;
    logic [YOC_W-1:0]   yoc_w;
    logic [DOC_W-1:0]   base_w;
    logic [DOC_W-1:0]   doy_full;
    logic [MPV_W-1:0]   mpv_w;
    logic [MP_W-1:0]    mp_w;
    logic               jan_feb;
    logic [YEAR_W-1:0]  year_w;
    logic [MONTH_W-1:0] month_w;
    logic [DOY_W-1:0]   mday_full;

    umtd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    assign secs_w = rsp.quot[SECS_W-1:0];
    assign sod_w  = rsp.rem[SOD_W-1:0];
    assign soh_w  = rsp.rem[SOH_W-1:0];
    assign z_w    = days_reg + DAYS_W'(EPOCH_SHIFT);

    // doc - doc/1460 + doc/36524 - doc/146096, with the last two as compares
    assign x_w = doc_reg - DOC_W'(rsp.quot[STEP_4Y-1:0])
                 + DOC_W'(doc_reg >= DOC_W'(DAYS_PER_CENT))
                 + DOC_W'(doc_reg >= DOC_W'(2 * DAYS_PER_CENT))
                 + DOC_W'(doc_reg >= DOC_W'(3 * DAYS_PER_CENT));

    assign yoc_w  = rsp.quot[YOC_W-1:0];
    assign base_w = DOC_W'(YEAR_DAYS) * DOC_W'(yoc_w) + DOC_W'(yoc_w >> 2)
                    - DOC_W'(yoc_w >= YOC_W'(100))
                    - DOC_W'(yoc_w >= YOC_W'(200))
                    - DOC_W'(yoc_w >= YOC_W'(300));
    assign doy_full = doc_reg - base_w;

    assign mpv_w = MPV_W'(5) * MPV_W'(doy_reg) + MPV_W'(2);

    assign mp_w      = rsp.quot[MP_W-1:0];
    assign jan_feb   = (mp_w >= MP_W'(MP_JAN));
    assign month_w   = jan_feb ? (mp_w - MONTH_W'(9)) : (mp_w + MONTH_W'(3));
    assign mday_full = doy_reg - mp_day_base(mp_w) + DOY_W'(1);
    assign year_w    = YEAR_W'(yoc_reg) + YEAR_W'(cyc_reg) * YEAR_W'(YEARS_PER_CYCLE)
                       + YEAR_W'(jan_feb);

    always_comb begin
        state_next  = state_reg;
        milli_next  = milli_reg;
        days_next   = days_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        cyc_next    = cyc_reg;
        doc_next    = doc_reg;
        yoc_next    = yoc_reg;
        doy_next    = doy_reg;
        res_next    = res_reg;
        req         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    req.start     = 1'b1;
                    req.divisor   = REM_W'(MS_PER_SEC);
                    req.rem_init  = REM_W'(millis >> STEP_MS);
                    req.quot_init = QUO_W'(millis) << (QUO_W - STEP_MS);
                    req.steps     = CNT_W'(STEP_MS);
                    state_next    = ST_MS;
                end
            end
            ST_MS: begin
                if (rsp.done) begin
                    milli_next    = rsp.rem[MILLI_W-1:0];
                    req.start     = 1'b1;
                    req.divisor   = REM_W'(SEC_PER_DAY);
                    req.rem_init  = REM_W'(secs_w >> STEP_DAY);
                    req.quot_init = QUO_W'(secs_w) << (QUO_W - STEP_DAY);
                    req.steps     = CNT_W'(STEP_DAY);
                    state_next    = ST_DAY;
                end
            end
            ST_DAY: begin
                if (rsp.done) begin
                    days_next     = rsp.quot[DAYS_W-1:0];
                    req.start     = 1'b1;
                    req.divisor   = REM_W'(SEC_PER_HOUR);
                    req.rem_init  = REM_W'(sod_w >> STEP_HR);
                    req.quot_init = QUO_W'(sod_w) << (QUO_W - STEP_HR);
                    req.steps     = CNT_W'(STEP_HR);
                    state_next    = ST_HR;
                end
            end
            ST_HR: begin
                if (rsp.done) begin
                    hour_next     = rsp.quot[HOUR_W-1:0];
                    req.start     = 1'b1;
                    req.divisor   = REM_W'(SEC_PER_MIN);
                    req.rem_init  = REM_W'(soh_w >> STEP_MIN);
                    req.quot_init = QUO_W'(soh_w) << (QUO_W - STEP_MIN);
                    req.steps     = CNT_W'(STEP_MIN);
                    state_next    = ST_MIN;
                end
            end
            ST_MIN: begin
                if (rsp.done) begin
                    minute_next   = rsp.quot[MIN_W-1:0];
                    second_next   = rsp.rem[SEC_W-1:0];
                    req.start     = 1'b1;
                    req.divisor   = REM_W'(CYCLE_DAYS);
                    req.rem_init  = REM_W'(z_w >> STEP_CYC);
                    req.quot_init = QUO_W'(z_w) << (QUO_W - STEP_CYC);
                    req.steps     = CNT_W'(STEP_CYC);
                    state_next    = ST_CYC;
                end
            end
            ST_CYC: begin
                if (rsp.done) begin
                    cyc_next      = rsp.quot[CYC_W-1:0];
                    doc_next      = rsp.rem[DOC_W-1:0];
                    req.start     = 1'b1;
                    req.divisor   = REM_W'(DAYS_PER_4Y);
                    req.rem_init  = REM_W'(rsp.rem >> STEP_4Y);
                    req.quot_init = QUO_W'(rsp.rem) << (QUO_W - STEP_4Y);
                    req.steps     = CNT_W'(STEP_4Y);
                    state_next    = ST_4Y;
                end
            end
            ST_4Y: begin
                if (rsp.done) begin
                    req.start     = 1'b1;
                    req.divisor   = REM_W'(YEAR_DAYS);
                    req.rem_init  = REM_W'(x_w >> STEP_YOC);
                    req.quot_init = QUO_W'(x_w) << (QUO_W - STEP_YOC);
                    req.steps     = CNT_W'(STEP_YOC);
                    state_next    = ST_YOC;
                end
            end
            ST_YOC: begin
                if (rsp.done) begin
                    yoc_next   = yoc_w;
                    doy_next   = doy_full[DOY_W-1:0];
                    state_next = ST_MPI;
                end
            end
            ST_MPI: begin
                req.start     = 1'b1;
                req.divisor   = REM_W'(MP_DIVISOR);
                req.rem_init  = REM_W'(mpv_w >> STEP_MP);
                req.quot_init = QUO_W'(mpv_w) << (QUO_W - STEP_MP);
                req.steps     = CNT_W'(STEP_MP);
                state_next    = ST_MP;
            end
            ST_MP: begin
                if (rsp.done) begin
                    if (32'(year_w) <= 32'(LAST_YEAR)) begin
                        res_next.in_range = 1'b1;
                        res_next.year     = year_w;
                        res_next.month    = month_w;
                        res_next.day      = mday_full[DAY_W-1:0];
                        res_next.hour     = hour_reg;
                        res_next.minute   = minute_reg;
                        res_next.second   = second_reg;
                        res_next.milli    = milli_reg;
                    end else begin
                        res_next = '0;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        milli_reg  <= milli_next;
        days_reg   <= days_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
        cyc_reg    <= cyc_next;
        doc_reg    <= doc_next;
        yoc_reg    <= yoc_next;
        doy_reg    <= doy_next;
        res_reg    <= res_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

endmodule

>>> src/unix_ms_to_utc_date_top.sv
// Top level of the Unix millisecond timestamp to UTC calendar converter.
// Depends on umtd_pkg and umtd_seq (which holds umtd_div).
//
// One request carries a 48-bit count of milliseconds since 1970-01-01 00:00:00 UTC and
// returns the proleptic Gregorian year, month, day, hour, minute, second and millisecond.
// Years past 9999 give m_in_range low and all other fields zero. Every conversion runs
// through a single bit-serial divider that yields one quotient bit per cycle over eight
// chained divisions, and the result appears on m_valid when it moves into the output
// register. s_ready rises at the same edge, so a new request is accepted only once the
// previous conversion has finished and its result has moved into the output register.
// One finished result may wait in the output register while the next request is being
// converted; a second finished result then holds s_ready low until the first is taken.
module unix_ms_to_utc_date_top
    import umtd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [MS_W-1:0]    s_unix_millis,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_in_range,
    output logic [YEAR_W-1:0]  m_cal_year,
    output logic [MONTH_W-1:0] m_cal_month,
    output logic [DAY_W-1:0]   m_cal_day,
    output logic [HOUR_W-1:0]  m_clock_hour,
    output logic [MIN_W-1:0]   m_clock_minute,
    output logic [SEC_W-1:0]   m_clock_second,
    output logic [MILLI_W-1:0] m_clock_milli
);

    logic     seq_idle;
    logic     seq_valid;
    logic     take;
    cal_res_t seq_res;

    logic     m_valid_reg, m_valid_next;
    cal_res_t out_reg, out_next;

    umtd_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid & seq_idle),
        .millis    (s_unix_millis),
        .take      (take),
        .idle      (seq_idle),
        .res_valid (seq_valid),
        .res       (seq_res)
    );

    assign take = seq_valid & (~m_valid_reg | m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (take) begin
            m_valid_next = 1'b1;
            out_next     = seq_res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign s_ready        = seq_idle;
    assign m_valid        = m_valid_reg;
    assign m_in_range     = out_reg.in_range;
    assign m_cal_year     = out_reg.year;
    assign m_cal_month    = out_reg.month;
    assign m_cal_day      = out_reg.day;
    assign m_clock_hour   = out_reg.hour;
    assign m_clock_minute = out_reg.minute;
    assign m_clock_second = out_reg.second;
    assign m_clock_milli  = out_reg.milli;

endmodule

>>> src/umtd_chk.sv
// Port-level checker for the timestamp converter, bound to the top level.
// Depends on umtd_pkg and unix_ms_to_utc_date_top.
module umtd_chk
    import umtd_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [MS_W-1:0]    s_unix_millis,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_in_range,
    input logic [YEAR_W-1:0]  m_cal_year,
    input logic [MONTH_W-1:0] m_cal_month,
    input logic [DAY_W-1:0]   m_cal_day,
    input logic [HOUR_W-1:0]  m_clock_hour,
    input logic [MIN_W-1:0]   m_clock_minute,
    input logic [SEC_W-1:0]   m_clock_second,
    input logic [MILLI_W-1:0] m_clock_milli
);

    // waiting request holds
    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_unix_millis))
        else $error("request changed while waiting");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_in_range) && $stable(m_cal_year)
            && $stable(m_cal_month) && $stable(m_cal_day) && $stable(m_clock_hour)
            && $stable(m_clock_minute) && $stable(m_clock_second) && $stable(m_clock_milli))
        else $error("result changed while stalled");

    // out of range gives all-zero fields
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_range |-> m_cal_year == '0 && m_cal_month == '0 && m_cal_day == '0
            && m_clock_hour == '0 && m_clock_minute == '0 && m_clock_second == '0
            && m_clock_milli == '0)
        else $error("out-of-range result not zeroed");

    // fields stay within calendar limits
    a_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_in_range |-> m_cal_year >= YEAR_W'(EPOCH_YEAR)
            && m_cal_year <= YEAR_W'(LAST_YEAR)
            && m_cal_month >= MONTH_W'(1) && m_cal_month <= MONTH_W'(12)
            && m_cal_day >= DAY_W'(1)
            && m_clock_hour < HOUR_W'(24) && m_clock_minute < MIN_W'(SEC_PER_MIN)
            && m_clock_second < SEC_W'(SEC_PER_MIN) && m_clock_milli < MILLI_W'(MS_PER_SEC))
        else $error("calendar field out of limits");

    // one request at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while converting");

endmodule

bind unix_ms_to_utc_date_top umtd_chk u_umtd_chk (.*);
